>>> rtl/four_level_page_table_walker_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the four-level page table walker
// Shared concurrent assertion forms, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset
`define FLPTW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define FLPTW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/flptw_pkg.sv
// ----------------------------------------------------------------------------
// flptw_pkg
// Types and constants shared by the page table walker and its checker.
// ----------------------------------------------------------------------------
package flptw_pkg;

  // Sizes
  localparam int unsigned MemWordsDefault = 16384;
  localparam int unsigned EntryW          = 64;
  localparam int unsigned FrameW          = 40;
  localparam int unsigned VaW             = 48;
  localparam int unsigned IdxW            = 9;
  localparam int unsigned TableWords      = 512;
  localparam int unsigned FrameShift      = 12;
  localparam int unsigned PhysW           = 52;
  localparam int unsigned StatusW         = 3;
  localparam int unsigned WordIdxW        = 14;
  localparam int unsigned LevelW          = 2;
  localparam int unsigned PAddrW          = 4;
  localparam int unsigned PDataW          = 64;

  // Entry bits
  localparam int unsigned BitPresent = 0;
  localparam int unsigned BitLarge   = 7;

  // Request kinds
  localparam logic ReqWrite     = 1'b0;
  localparam logic ReqTranslate = 1'b1;

  // Register index (address bit 3 selects the 64-bit register slot)
  localparam logic RegRootFrame = 1'b0;

  // Table levels, top first
  localparam logic [LevelW-1:0] LvlPml4 = 2'd0;
  localparam logic [LevelW-1:0] LvlPdpt = 2'd1;
  localparam logic [LevelW-1:0] LvlPd   = 2'd2;
  localparam logic [LevelW-1:0] LvlPt   = 2'd3;

  // Result status codes
  localparam logic [StatusW-1:0] StOk       = 3'd0;
  localparam logic [StatusW-1:0] StAbsentL4 = 3'd1;
  localparam logic [StatusW-1:0] StAbsentL3 = 3'd2;
  localparam logic [StatusW-1:0] StAbsentL2 = 3'd3;
  localparam logic [StatusW-1:0] StAbsentL1 = 3'd4;
  localparam logic [StatusW-1:0] StPage1g   = 3'd5;
  localparam logic [StatusW-1:0] StPage2m   = 3'd6;
  localparam logic [StatusW-1:0] StOutside  = 3'd7;

  // Request beat
  typedef struct packed {
    logic                req_type;
    logic [WordIdxW-1:0] word_index;
    logic [EntryW-1:0]   entry_value;
    logic [VaW-1:0]      vaddr;
  } req_t;

  // Result beat
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [PhysW-1:0]   phys_page_addr;
  } rsp_t;

endpackage

>>> rtl/flptw_step.sv
// ----------------------------------------------------------------------------
// flptw_step
// Shared level step: bounds check of a table frame and word address of the
// entry selected by one level's nine virtual address bits.
// ----------------------------------------------------------------------------
module flptw_step #(
  parameter int unsigned MEM_WORDS = flptw_pkg::MemWordsDefault
) (
  input  logic [flptw_pkg::FrameW-1:0]   frame_i,
  input  logic [flptw_pkg::VaW-1:0]      va_i,
  input  logic [flptw_pkg::LevelW-1:0]   level_i,
  output logic                           outside_o,
  output logic [$clog2(MEM_WORDS)-1:0]   addr_o
);
  import flptw_pkg::*;

  localparam int unsigned AddrW  = $clog2(MEM_WORDS);
  localparam int unsigned Tables = MEM_WORDS / TableWords;
  localparam int unsigned TabW   = $clog2(Tables);

  logic [IdxW-1:0] idx;

  // Pick the nine index bits of this level
  always_comb begin
    unique case (level_i)
      LvlPml4: idx = va_i[FrameShift + 3*IdxW +: IdxW];
      LvlPdpt: idx = va_i[FrameShift + 2*IdxW +: IdxW];
      LvlPd:   idx = va_i[FrameShift + IdxW +: IdxW];
      default: idx = va_i[FrameShift +: IdxW];
    endcase
  end

  // Only whole tables inside the memory count
  assign outside_o = (frame_i >= FrameW'(Tables));
  assign addr_o    = AddrW'({frame_i[TabW-1:0], idx});

endmodule

>>> rtl/four_level_page_table_walker_unit.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker_unit
// Four-level page table walk over a local table memory of 64-bit words.
//
//   Channel   Ports                        Handshake
//   request   start_i, req_i               taken when start_i && !busy_o
//   result    done_o, rsp_o                one cycle, cannot be held off
//   config    psel_i .. pready_o (APB)     written at access with pready_o
//
// A table write takes the accept cycle; its result shows in the next cycle.
// A translation reads one level per cycle through the single memory read
// port: accept, then a read-and-check step per level down to the page table,
// result in the next cycle; busy_o falls with the result.
// After reset a clearing pass zeroes the memory, one word a cycle, with
// busy_o high; configuration writes are taken as ever.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_unit #(
  parameter int unsigned MEM_WORDS = flptw_pkg::MemWordsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  flptw_pkg::req_t               req_i,
  output logic                          busy_o,
  output logic                          done_o,
  output flptw_pkg::rsp_t               rsp_o,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [flptw_pkg::PAddrW-1:0]  paddr_i,
  input  logic [flptw_pkg::PDataW-1:0]  pwdata_i,
  output logic [flptw_pkg::PDataW-1:0]  prdata_o,
  output logic                          pready_o
);
  import flptw_pkg::*;

  localparam int unsigned AddrW = $clog2(MEM_WORDS);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(MEM_WORDS - 1);

  localparam logic [1:0] StateClear = 2'd0;
  localparam logic [1:0] StateIdle  = 2'd1;
  localparam logic [1:0] StateWalk  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic [LevelW-1:0] lvl_q, lvl_d;
  logic [VaW-1:0]    va_q, va_d;
  logic              done_q, done_d;
  rsp_t              rsp_q, rsp_d;
  logic [FrameW-1:0] root_q;

  logic [EntryW-1:0] mem_q [MEM_WORDS];
  logic [EntryW-1:0] rd_data_q;
  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_waddr;
  logic [EntryW-1:0] mem_wdata;

  logic [FrameW-1:0] step_frame;
  logic [VaW-1:0]    step_va;
  logic [LevelW-1:0] step_lvl;
  logic              step_outside;
  logic [AddrW-1:0]  step_addr;

  logic [31:0]       widx_ext;
  logic              widx_ok;
  logic [FrameW-1:0] ent_frame;
  logic              cfg_wr;

  // Configuration register
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o;
  assign prdata_o = (paddr_i[3] == RegRootFrame) ? PDataW'(root_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_wr && paddr_i[3] == RegRootFrame) begin
      root_q <= pwdata_i[FrameW-1:0];
    end
  end

  // Shared level step unit
  flptw_step #(
    .MEM_WORDS (MEM_WORDS)
  ) u_step (
    .frame_i   (step_frame),
    .va_i      (step_va),
    .level_i   (step_lvl),
    .outside_o (step_outside),
    .addr_o    (step_addr)
  );

  assign widx_ext  = {{(32 - WordIdxW){1'b0}}, req_i.word_index};
  assign widx_ok   = (widx_ext < 32'(MEM_WORDS));
  assign ent_frame = rd_data_q[FrameShift +: FrameW];

  // Sequencer: clear, take requests, walk one level per cycle
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    lvl_d      = lvl_q;
    va_d       = va_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    mem_we     = 1'b0;
    mem_waddr  = clr_q;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    step_frame = root_q;
    step_va    = req_i.vaddr;
    step_lvl   = LvlPml4;

    if (state_q == StateWalk) begin
      step_frame = ent_frame;
      step_va    = va_q;
      step_lvl   = lvl_q + 2'd1;
    end

    unique case (state_q)
      StateClear: begin
        mem_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == LastAddr) begin
          state_d = StateIdle;
        end
      end
      StateIdle: begin
        if (start_i) begin
          if (req_i.req_type == ReqWrite) begin
            mem_we    = widx_ok;
            mem_waddr = widx_ext[AddrW-1:0];
            mem_wdata = req_i.entry_value;
            done_d    = 1'b1;
            rsp_d     = '{status: StOk, phys_page_addr: '0};
          end else if (step_outside) begin
            done_d = 1'b1;
            rsp_d  = '{status: StOutside, phys_page_addr: '0};
          end else begin
            mem_re  = 1'b1;
            va_d    = req_i.vaddr;
            lvl_d   = LvlPml4;
            state_d = StateWalk;
          end
        end
      end
      StateWalk: begin
        rsp_d.phys_page_addr = '0;
        priority if (!rd_data_q[BitPresent]) begin
          unique case (lvl_q)
            LvlPml4: rsp_d.status = StAbsentL4;
            LvlPdpt: rsp_d.status = StAbsentL3;
            LvlPd:   rsp_d.status = StAbsentL2;
            default: rsp_d.status = StAbsentL1;
          endcase
          done_d  = 1'b1;
          state_d = StateIdle;
        end else if (lvl_q == LvlPdpt && rd_data_q[BitLarge]) begin
          rsp_d.status = StPage1g;
          done_d       = 1'b1;
          state_d      = StateIdle;
        end else if (lvl_q == LvlPd && rd_data_q[BitLarge]) begin
          rsp_d.status = StPage2m;
          done_d       = 1'b1;
          state_d      = StateIdle;
        end else if (lvl_q == LvlPt) begin
          rsp_d.status         = StOk;
          rsp_d.phys_page_addr = {ent_frame, {FrameShift{1'b0}}};
          done_d               = 1'b1;
          state_d              = StateIdle;
        end else if (step_outside) begin
          rsp_d.status = StOutside;
          done_d       = 1'b1;
          state_d      = StateIdle;
        end else begin
          mem_re = 1'b1;
          lvl_d  = lvl_q + 2'd1;
        end
      end
      default: begin
        state_d = StateIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateClear;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  // Walk payload and result registers
  always_ff @(posedge clk_i) begin
    lvl_q <= lvl_d;
    va_q  <= va_d;
    rsp_q <= rsp_d;
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[step_addr];
    end
  end

  assign busy_o = (state_q != StateIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

>>> rtl/flptw_checker.sv
// ----------------------------------------------------------------------------
// flptw_checker
// Port-level checks on the page table walker, bound to the top level.
// ----------------------------------------------------------------------------
`include "four_level_page_table_walker_unit_macros.svh"

module flptw_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start_i,
  input flptw_pkg::req_t req_i,
  input logic            busy_o,
  input logic            done_o,
  input flptw_pkg::rsp_t rsp_o
);
  import flptw_pkg::*;

  logic wr_beat;
  logic rsp_clean;

  assign wr_beat   = start_i && !busy_o && (req_i.req_type == ReqWrite);
  assign rsp_clean = (rsp_o.status == StOk) && (rsp_o.phys_page_addr == '0);

  // A table write answers in the next cycle with a clean ok
  `FLPTW_ASSERT(a_write_result, wr_beat |=> done_o && rsp_clean, "write beat not answered")

  // Only a successful walk carries a page address
  `FLPTW_ASSERT(a_addr_only_ok, done_o && rsp_o.status != StOk |-> rsp_o.phys_page_addr == '0, "addr on fail")

  // A result beat leaves the block ready for the next request
  `FLPTW_ASSERT(a_done_idle, done_o |-> !busy_o, "result beat while still busy")

  // Out of idle, a result needs an accepted request the cycle before
  `FLPTW_ASSERT(a_no_spurious, done_o && !$past(busy_o) |-> $past(start_i), "result without request")

  // Reset keeps the result strobe low
  `FLPTW_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !done_o || rst_ni, "strobe during reset")

endmodule

bind four_level_page_table_walker_unit flptw_checker u_flptw_checker (.*);
